// File: design/swq_pkg.sv
// ----------------------------------------------------------------------------
// swq_pkg
// Shared constants, codes and types of the semaphore wait queue table.
// ----------------------------------------------------------------------------
package swq_pkg;

  localparam int unsigned NumProcs = 32;
  localparam int unsigned KeyBits  = 32;
  localparam int unsigned IdxW     = $clog2(NumProcs);
  localparam int unsigned LenW     = IdxW + 1;

  // command codes
  localparam logic [1:0] CmdBlock   = 2'd0;
  localparam logic [1:0] CmdUnblock = 2'd1;
  localparam logic [1:0] CmdPull    = 2'd2;
  localparam logic [1:0] CmdPeek    = 2'd3;

  // status codes
  localparam logic [1:0] StDone     = 2'd0;
  localparam logic [1:0] StNotFound = 2'd1;
  localparam logic [1:0] StNoFree   = 2'd2;
  localparam logic [1:0] StAlready  = 2'd3;

  // scan request from the sequencer to the scan unit
  typedef struct packed {
    logic              start;
    logic [KeyBits-1:0] key;
  } scan_req_t;

  // scan result back to the sequencer
  typedef struct packed {
    logic            done;
    logic            hit;
    logic [IdxW-1:0] hit_idx;
    logic            free_ok;
    logic [IdxW-1:0] free_idx;
  } scan_rsp_t;

endpackage

// File: design/semaphore_wait_queue_table.sv
// ----------------------------------------------------------------------------
// semaphore_wait_queue_table
// Table of semaphore descriptors, each holding a FIFO of blocked processes.
// ----------------------------------------------------------------------------
// channel   direction  ports                               handshake
// request   in         cmd_i, sem_key_i, proc_id_i         start && !busy
// result    out        status_o, proc_out_o                done_o (one cycle)
//
// Block, unblock and peek keep busy high for one key scan through the
// shared compare unit. A pull-out keeps busy high through a setup state,
// a walk that follows one queue link at a time, and an update state; it
// ends after the setup when the process is not waiting. The result strobe
// comes in the first cycle with busy low, so a new request can be taken at
// the earliest in the cycle of the strobe.
// Reset clears the in-use and waiting bits; no clearing pass is needed.
// The result cannot be stalled.
module semaphore_wait_queue_table (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start,
  output logic                                busy,
  input  logic [1:0]                          cmd_i,
  input  logic [31:0]                         sem_key_i,
  input  logic [4:0]                          proc_id_i,
  output logic                                done_o,
  output logic [1:0]                          status_o,
  output logic [4:0]                          proc_out_o
);

  localparam int unsigned N = swq_pkg::NumProcs;
  localparam int unsigned W = swq_pkg::IdxW;
  localparam int unsigned L = swq_pkg::LenW;

  // sequencer states
  localparam logic [2:0] SIdle  = 3'd0;
  localparam logic [2:0] SScan  = 3'd1;
  localparam logic [2:0] SWalk  = 3'd2;
  localparam logic [2:0] SWRd   = 3'd3;
  localparam logic [2:0] SFin   = 3'd4;

  logic [2:0]   st_q, st_d;
  logic [1:0]   cmd_q;
  logic [swq_pkg::KeyBits-1:0] key_q;
  logic [W-1:0] pid_q;
  logic         pid_ok_q;

  // descriptor and process state
  logic [swq_pkg::KeyBits-1:0] desc_key [N];
  logic [N-1:0] in_use_q;
  logic [W-1:0] q_first [N];
  logic [W-1:0] q_last  [N];
  logic [L-1:0] q_len   [N];
  logic [W-1:0] p_link  [N];
  logic [W-1:0] p_desc  [N];
  logic [N-1:0] waiting_q;

  // walk registers
  logic [W-1:0] cur_q, prev_q, wd_q;
  logic         prev_ok_q;
  logic [L-1:0] n_q;

  logic [W-1:0] key_addr;
  logic [swq_pkg::KeyBits-1:0] key_rd_q;
  swq_pkg::scan_req_t sreq;
  swq_pkg::scan_rsp_t srsp;

  logic         accept;
  logic         done_q;
  logic [1:0]   stat_q;
  logic [4:0]   pout_q;

  assign accept     = start && (st_q == SIdle);
  assign busy       = (st_q != SIdle);
  assign done_o     = done_q;
  assign status_o   = stat_q;
  assign proc_out_o = pout_q;

  assign sreq.start = accept && (cmd_i != swq_pkg::CmdPull);
  assign sreq.key   = swq_pkg::KeyBits'(sem_key_i);

  // key memory read port for the scan unit
  always_ff @(posedge clk_i) begin
    key_rd_q <= desc_key[key_addr];
  end

  swq_scan u_scan (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (sreq),
    .in_use_i   (in_use_q),
    .key_rd_i   (key_rd_q),
    .key_addr_o (key_addr),
    .rsp_o      (srsp)
  );

  // sequencer
  always_comb begin
    st_d = st_q;
    case (st_q)
      SIdle: begin
        if (accept) begin
          st_d = (cmd_i == swq_pkg::CmdPull) ? SWalk : SScan;
        end
      end
      SScan:   if (srsp.done) st_d = SIdle;
      SWalk: begin
        if (!pid_ok_q || !waiting_q[pid_q]) st_d = SIdle;
        else st_d = SWRd;
      end
      // keep walking until the process is reached or the queue ends
      SWRd: begin
        if (!(cur_q != pid_q && n_q < q_len[wd_q])) st_d = SFin;
      end
      SFin:    st_d = SIdle;
      default: st_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= SIdle;
    end else begin
      st_q <= st_d;
    end
  end

  // request capture
  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q    <= cmd_i;
      key_q    <= swq_pkg::KeyBits'(sem_key_i);
      pid_q    <= W'(proc_id_i);
      pid_ok_q <= ({27'd0, proc_id_i} < N);
    end
  end

  // state update, walk and result
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_use_q  <= '0;
      waiting_q <= '0;
      done_q    <= 1'b0;
      stat_q    <= swq_pkg::StDone;
      pout_q    <= '0;
      n_q       <= '0;
      for (int i = 0; i < N; i++) q_len[i] <= '0;
    end else begin
      done_q <= 1'b0;
      // key scan finished: apply block, unblock or peek
      if (st_q == SScan && srsp.done) begin
        done_q <= 1'b1;
        stat_q <= swq_pkg::StNotFound;
        pout_q <= '0;
        case (cmd_q)
          swq_pkg::CmdBlock: begin
            if (!pid_ok_q) begin
              stat_q <= swq_pkg::StNotFound;
            end else if (waiting_q[pid_q]) begin
              stat_q <= swq_pkg::StAlready;
            end else if (srsp.hit) begin
              if (q_len[srsp.hit_idx] == '0) q_first[srsp.hit_idx] <= pid_q;
              else p_link[q_last[srsp.hit_idx]] <= pid_q;
              q_last[srsp.hit_idx] <= pid_q;
              q_len[srsp.hit_idx]  <= q_len[srsp.hit_idx] + 1'b1;
              p_desc[pid_q]        <= srsp.hit_idx;
              waiting_q[pid_q]     <= 1'b1;
              stat_q               <= swq_pkg::StDone;
            end else if (srsp.free_ok) begin
              in_use_q[srsp.free_idx] <= 1'b1;
              desc_key[srsp.free_idx] <= key_q;
              q_first[srsp.free_idx]  <= pid_q;
              q_last[srsp.free_idx]   <= pid_q;
              q_len[srsp.free_idx]    <= L'(1);
              p_desc[pid_q]           <= srsp.free_idx;
              waiting_q[pid_q]        <= 1'b1;
              stat_q                  <= swq_pkg::StDone;
            end else begin
              stat_q <= swq_pkg::StNoFree;
            end
          end
          swq_pkg::CmdUnblock, swq_pkg::CmdPeek: begin
            if (srsp.hit && q_len[srsp.hit_idx] != '0) begin
              stat_q <= swq_pkg::StDone;
              pout_q <= 5'(q_first[srsp.hit_idx]);
              if (cmd_q == swq_pkg::CmdUnblock) begin
                q_first[srsp.hit_idx] <= p_link[q_first[srsp.hit_idx]];
                q_len[srsp.hit_idx]   <= q_len[srsp.hit_idx] - 1'b1;
                waiting_q[q_first[srsp.hit_idx]] <= 1'b0;
                if (q_len[srsp.hit_idx] == L'(1)) in_use_q[srsp.hit_idx] <= 1'b0;
              end
            end
          end
          default: ;
        endcase
      end
      // pull-out: set up the walk
      if (st_q == SWalk) begin
        if (!pid_ok_q || !waiting_q[pid_q]) begin
          done_q <= 1'b1;
          stat_q <= swq_pkg::StNotFound;
          pout_q <= '0;
        end else begin
          wd_q      <= p_desc[pid_q];
          cur_q     <= q_first[p_desc[pid_q]];
          prev_ok_q <= 1'b0;
          n_q       <= '0;
        end
      end
      // pull-out: follow one link per cycle
      if (st_q == SWRd) begin
        if (cur_q != pid_q && n_q < q_len[wd_q]) begin
          prev_q    <= cur_q;
          prev_ok_q <= 1'b1;
          cur_q     <= p_link[cur_q];
          n_q       <= n_q + 1'b1;
        end
      end
      if (st_q == SFin) begin
        done_q <= 1'b1;
        stat_q <= swq_pkg::StNotFound;
        pout_q <= '0;
        if (cur_q == pid_q && n_q < q_len[wd_q]) begin
          if (!prev_ok_q) q_first[wd_q] <= p_link[pid_q];
          else p_link[prev_q] <= p_link[pid_q];
          if (q_last[wd_q] == pid_q && prev_ok_q) q_last[wd_q] <= prev_q;
          q_len[wd_q]      <= q_len[wd_q] - 1'b1;
          waiting_q[pid_q] <= 1'b0;
          if (q_len[wd_q] == L'(1)) in_use_q[wd_q] <= 1'b0;
          pout_q <= 5'(pid_q);
          stat_q <= swq_pkg::StDone;
        end
      end
    end
  end

endmodule

// File: design/swq_scan.sv
// ----------------------------------------------------------------------------
// swq_scan
// Shared key compare unit: steps through descriptors one per cycle, finds
// the descriptor holding a key and the lowest free descriptor.
// ----------------------------------------------------------------------------
module swq_scan (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  swq_pkg::scan_req_t                     req_i,
  input  logic [swq_pkg::NumProcs-1:0]           in_use_i,
  input  logic [swq_pkg::KeyBits-1:0]            key_rd_i,
  output logic [swq_pkg::IdxW-1:0]               key_addr_o,
  output swq_pkg::scan_rsp_t                     rsp_o
);

  logic                       run_q, run_d;
  logic [swq_pkg::IdxW-1:0]   idx_q, idx_d;
  logic                       rd_vld_q, rd_vld_d;
  logic [swq_pkg::IdxW-1:0]   rd_idx_q;
  logic [swq_pkg::KeyBits-1:0] key_q;
  swq_pkg::scan_rsp_t         rsp_q, rsp_d;
  logic                       last_rd;

  assign key_addr_o = idx_q;
  assign rsp_o      = rsp_q;
  assign last_rd    = rd_vld_q && (rd_idx_q == swq_pkg::IdxW'(swq_pkg::NumProcs - 1));

  // sequencing: issue one key read per cycle, compare the registered data
  always_comb begin
    run_d    = run_q;
    idx_d    = idx_q;
    rd_vld_d = 1'b0;
    rsp_d    = rsp_q;
    rsp_d.done = 1'b0;
    if (req_i.start) begin
      run_d = 1'b1;
      idx_d = '0;
      rsp_d.hit = 1'b0;
      rsp_d.free_ok = 1'b0;
    end else begin
      if (run_q) begin
        rd_vld_d = 1'b1;
        if (idx_q == swq_pkg::IdxW'(swq_pkg::NumProcs - 1)) begin
          run_d = 1'b0;
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end
      if (rd_vld_q) begin
        if (in_use_i[rd_idx_q] && key_rd_i == key_q && !rsp_q.hit) begin
          rsp_d.hit     = 1'b1;
          rsp_d.hit_idx = rd_idx_q;
        end
        if (!in_use_i[rd_idx_q] && !rsp_q.free_ok) begin
          rsp_d.free_ok  = 1'b1;
          rsp_d.free_idx = rd_idx_q;
        end
        if (last_rd) begin
          rsp_d.done = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q    <= 1'b0;
      idx_q    <= '0;
      rd_vld_q <= 1'b0;
      rsp_q    <= '0;
    end else begin
      run_q    <= run_d;
      idx_q    <= idx_d;
      rd_vld_q <= rd_vld_d;
      rsp_q    <= rsp_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_idx_q <= idx_q;
    if (req_i.start) begin
      key_q <= req_i.key;
    end
  end

endmodule

// File: design/swq_checker.sv
// ----------------------------------------------------------------------------
// swq_checker
// Port-level checks of the semaphore wait queue table.
// ----------------------------------------------------------------------------
module swq_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       start,
  input logic       busy,
  input logic       done_o,
  input logic [1:0] status_o,
  input logic [4:0] proc_out_o
);

  // an accepted request makes the block busy
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> busy) else $error("request not taken");

  // result strobe only directly after a busy period
  a_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(busy)) else $error("stray result");

  // strobe lasts one cycle
  a_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o) else $error("result held");

  // failed results carry no process
  a_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && status_o != swq_pkg::StDone |-> proc_out_o == 5'd0)
    else $error("bad proc");

endmodule

bind semaphore_wait_queue_table swq_checker u_chk (.*);

// File: sim/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the semaphore wait queue table: a behavioral table
// predicts status and process for every request; results are compared in
// order. Directed corner requests first, then randomized block/unblock/
// pull-out/peek traffic over a small key pool, under several idle phases.
// ----------------------------------------------------------------------------
module testbench;

  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [31:0] key;
    logic [4:0]  pid;
  } sem_req_t;

  typedef struct packed {
    logic [1:0] status;
    logic [4:0] pid;
  } sem_rsp_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [1:0]  cmd_i = swq_pkg::CmdBlock;
  logic [31:0] sem_key_i = '0;
  logic [4:0]  proc_id_i = '0;
  logic        done_o;
  logic [1:0]  status_o;
  logic [4:0]  proc_out_o;

  semaphore_wait_queue_table dut (
    .clk_i, .rst_ni, .start, .busy, .cmd_i, .sem_key_i, .proc_id_i,
    .done_o, .status_o, .proc_out_o
  );

  always #5 clk_i = ~clk_i;

  // shadow table of descriptors and per-process queues
  bit          sh_used [swq_pkg::NumProcs];
  logic [31:0] sh_key  [swq_pkg::NumProcs];
  int          sh_fifo [swq_pkg::NumProcs][$];
  bit          sh_wait [swq_pkg::NumProcs];
  int          sh_home [swq_pkg::NumProcs];

  sem_req_t pending_reqs[$];
  sem_rsp_t expected_rsps[$];
  int  send_idle_pct = 0;
  int  errors = 0;
  int  n_sent = 0;
  int  n_checked = 0;
  int  st_seen [4];
  logic [31:0] key_pool [8];

  function automatic int find_key(logic [31:0] k);
    for (int d = 0; d < swq_pkg::NumProcs; d++)
      if (sh_used[d] && sh_key[d] == k) return d;
    return -1;
  endfunction

  // apply one request to the shadow table and return its result
  function automatic sem_rsp_t predict_wait_queue(sem_req_t r);
    sem_rsp_t o;
    int d;
    int p;
    o = '{status: swq_pkg::StNotFound, pid: '0};
    p = r.pid;
    case (r.cmd)
      swq_pkg::CmdBlock: begin
        if (sh_wait[p]) begin
          o.status = swq_pkg::StAlready;
        end else begin
          d = find_key(r.key);
          if (d < 0) begin
            for (int i = 0; i < swq_pkg::NumProcs; i++)
              if (!sh_used[i]) begin
                d = i;
                break;
              end
            if (d >= 0) begin
              sh_used[d] = 1'b1;
              sh_key[d] = r.key;
              sh_fifo[d].delete();
            end
          end
          if (d < 0) begin
            o.status = swq_pkg::StNoFree;
          end else begin
            sh_fifo[d].push_back(p);
            sh_wait[p] = 1'b1;
            sh_home[p] = d;
            o.status = swq_pkg::StDone;
          end
        end
      end
      swq_pkg::CmdUnblock, swq_pkg::CmdPeek: begin
        d = find_key(r.key);
        if (d >= 0 && sh_fifo[d].size() != 0) begin
          o.status = swq_pkg::StDone;
          o.pid = 5'(sh_fifo[d][0]);
          if (r.cmd == swq_pkg::CmdUnblock) begin
            void'(sh_fifo[d].pop_front());
            sh_wait[o.pid] = 1'b0;
            if (sh_fifo[d].size() == 0) sh_used[d] = 1'b0;
          end
        end
      end
      default: begin
        if (sh_wait[p]) begin
          d = sh_home[p];
          foreach (sh_fifo[d][i])
            if (sh_fifo[d][i] == p) begin
              sh_fifo[d].delete(i);
              break;
            end
          sh_wait[p] = 1'b0;
          if (sh_fifo[d].size() == 0) sh_used[d] = 1'b0;
          o.status = swq_pkg::StDone;
          o.pid = 5'(p);
        end
      end
    endcase
    return o;
  endfunction

  function automatic sem_req_t rand_req();
    sem_req_t r;
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 40) r.cmd = swq_pkg::CmdBlock;
    else if (sel < 65) r.cmd = swq_pkg::CmdUnblock;
    else if (sel < 85) r.cmd = swq_pkg::CmdPull;
    else r.cmd = swq_pkg::CmdPeek;
    r.key = ($urandom_range(0, 9) == 0) ? $urandom() : key_pool[$urandom_range(0, 7)];
    r.pid = 5'($urandom_range(0, swq_pkg::NumProcs - 1));
    return r;
  endfunction

  // driver: predict at acceptance, keep start high across back-to-back requests
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (start && !busy) begin
        expected_rsps.push_back(predict_wait_queue('{cmd_i, sem_key_i, proc_id_i}));
        n_sent++;
      end
      if ((!start || !busy) && pending_reqs.size() != 0 &&
          $urandom_range(0, 99) >= send_idle_pct) begin
        sem_req_t r;
        r = pending_reqs.pop_front();
        start <= 1'b1;
        cmd_i <= r.cmd;
        sem_key_i <= r.key;
        proc_id_i <= r.pid;
      end else if (!start || !busy) begin
        start <= 1'b0;
      end
    end
  end

  // monitor: each strobe is compared with the oldest expectation
  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      if (expected_rsps.size() == 0) begin
        $display("%0t: unexpected result status=%0d proc=%0d", $time, status_o, proc_out_o);
        errors++;
      end else begin
        sem_rsp_t e;
        e = expected_rsps.pop_front();
        st_seen[e.status]++;
        n_checked++;
        if (status_o !== e.status) begin
          $display("%0t: status expected %0d actual %0d", $time, e.status, status_o);
          errors++;
        end
        if (proc_out_o !== e.pid) begin
          $display("%0t: proc_out expected %0d actual %0d", $time, e.pid, proc_out_o);
          errors++;
        end
      end
    end
  end

  initial begin
    int phase_pct [4];
    phase_pct = '{0, 70, 0, 31};
    foreach (key_pool[i]) key_pool[i] = $urandom();
    key_pool[0] = '0;
    key_pool[1] = '1;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: unknown keys, extremes, already blocked, pull-out paths
    pending_reqs.push_back('{swq_pkg::CmdUnblock, 32'h0, 5'd0});
    pending_reqs.push_back('{swq_pkg::CmdPeek, 32'hffff_ffff, 5'd31});
    pending_reqs.push_back('{swq_pkg::CmdPull, 32'h0, 5'd31});
    pending_reqs.push_back('{swq_pkg::CmdBlock, 32'h0, 5'd0});
    pending_reqs.push_back('{swq_pkg::CmdBlock, 32'hffff_ffff, 5'd31});
    pending_reqs.push_back('{swq_pkg::CmdBlock, 32'h0, 5'd0});
    pending_reqs.push_back('{swq_pkg::CmdBlock, 32'h0, 5'd5});
    pending_reqs.push_back('{swq_pkg::CmdBlock, 32'h0, 5'd10});
    pending_reqs.push_back('{swq_pkg::CmdPeek, 32'h0, 5'd0});
    pending_reqs.push_back('{swq_pkg::CmdPull, 32'h1234, 5'd5});
    pending_reqs.push_back('{swq_pkg::CmdPull, 32'h0, 5'd10});
    pending_reqs.push_back('{swq_pkg::CmdUnblock, 32'h0, 5'd0});
    pending_reqs.push_back('{swq_pkg::CmdUnblock, 32'h0, 5'd0});
    pending_reqs.push_back('{swq_pkg::CmdUnblock, 32'hffff_ffff, 5'd0});
    // fill the table with distinct keys, then block a process that already waits
    for (int i = 0; i < swq_pkg::NumProcs; i++)
      pending_reqs.push_back('{swq_pkg::CmdBlock, 32'h8000_0000 | i, i[4:0]});
    pending_reqs.push_back('{swq_pkg::CmdBlock, 32'h5555_aaaa, 5'd0});
    for (int i = 0; i < swq_pkg::NumProcs; i++)
      pending_reqs.push_back('{swq_pkg::CmdPull, 32'h0, i[4:0]});

    // random phases, each drained before the next
    foreach (phase_pct[ph]) begin
      wait (pending_reqs.size() == 0 && expected_rsps.size() == 0);
      send_idle_pct = phase_pct[ph];
      for (int i = 0; i < 225; i++) pending_reqs.push_back(rand_req());
    end
    wait (pending_reqs.size() == 0 && !start && expected_rsps.size() == 0);
    repeat (50) @(posedge clk_i);

    $display("Covered %0d requests, %0d results: done %0d, not found %0d,",
             n_sent, n_checked, st_seen[swq_pkg::StDone], st_seen[swq_pkg::StNotFound]);
    $display("no free descriptor %0d, already blocked %0d.",
             st_seen[swq_pkg::StNoFree], st_seen[swq_pkg::StAlready]);
    if (errors == 0 && expected_rsps.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
